// ----- rtl/lrut_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrut_pkg: shared types and codes for the lru list tracker
// Request and result payloads, request and status codes, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package lrut_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int DEF_KEY_BITS = 16;
  // free-slot search width per cycle
  localparam int SCAN_W       = 64;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_TOUCH  = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;
  localparam logic [1:0] REQ_EVICT  = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOT_USED = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] entry_key;
    logic [5:0]  slot_handle;
  } lrut_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic        evicted_valid;
    logic [15:0] evicted_key;
    logic [6:0]  occupancy;
  } lrut_out_t;

  typedef struct packed {
    logic       load_req;
    logic       echo_handle;
    logic       rd_en;
    logic       rd_oldest;
    logic [1:0] set_status;
    logic       unlink;
    logic       pop;
    logic       release_slot;
    logic       scan_start;
    logic       scan_step;
    logic       link_self;
    logic       link_prev;
    logic       load_out;
  } lrut_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic list_full;
    logic oldest_nil;
    logic handle_ok;
    logic handle_newest;
    logic scan_found;
    logic out_busy;
  } lrut_stat_t;

endpackage
`default_nettype wire

// ----- rtl/lrut_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrut_ctrl: request sequencer
// Decodes each request and steps the datapath through unlink, free-slot
// search and relink as the request needs, then hands the result to the output register.
// ----------------------------------------------------------------------------
module lrut_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic [1:0]        in_req_type,
  input  wire lrut_pkg::lrut_stat_t stat,
  output logic                   in_stall,
  output lrut_pkg::lrut_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_UNLINK    = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_LINK_SELF = 3'd3;
  localparam logic [2:0] S_LINK_PREV = 3'd4;
  localparam logic [2:0] S_DONE      = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] req_r, req_nxt;

  always_comb begin
    state_nxt = state_r;
    req_nxt   = req_r;
    cmd       = '0;
    in_stall  = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          req_nxt      = in_req_type;
          unique case (in_req_type) inside
            lrut_pkg::REQ_INSERT: begin
              if (stat.list_full) begin
                cmd.rd_en     = 1'b1;
                cmd.rd_oldest = 1'b1;
                state_nxt     = S_UNLINK;
              end else begin
                cmd.scan_start = 1'b1;
                state_nxt      = S_SCAN;
              end
            end
            lrut_pkg::REQ_EVICT: begin
              if (stat.count_zero || stat.oldest_nil) begin
                cmd.set_status = lrut_pkg::ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                cmd.rd_en     = 1'b1;
                cmd.rd_oldest = 1'b1;
                state_nxt     = S_UNLINK;
              end
            end
            lrut_pkg::REQ_TOUCH, lrut_pkg::REQ_REMOVE: begin
              cmd.echo_handle = 1'b1;
              if (stat.count_zero) begin
                cmd.set_status = lrut_pkg::ST_EMPTY;
                state_nxt      = S_DONE;
              end else if (!stat.handle_ok) begin
                cmd.set_status = lrut_pkg::ST_NOT_USED;
                state_nxt      = S_DONE;
              end else if (in_req_type == lrut_pkg::REQ_TOUCH && stat.handle_newest) begin
                state_nxt = S_DONE;
              end else begin
                cmd.rd_en = 1'b1;
                state_nxt = S_UNLINK;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_UNLINK: begin
        cmd.unlink = 1'b1;
        unique case (req_r)
          lrut_pkg::REQ_INSERT: begin
            cmd.pop          = 1'b1;
            cmd.release_slot = 1'b1;
            cmd.scan_start   = 1'b1;
            state_nxt        = S_SCAN;
          end
          lrut_pkg::REQ_EVICT: begin
            cmd.pop          = 1'b1;
            cmd.release_slot = 1'b1;
            state_nxt        = S_DONE;
          end
          lrut_pkg::REQ_TOUCH: state_nxt = S_LINK_SELF;
          lrut_pkg::REQ_REMOVE: begin
            cmd.release_slot = 1'b1;
            state_nxt        = S_DONE;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_found) begin
          state_nxt = S_LINK_SELF;
        end
      end
      S_LINK_SELF: begin
        cmd.link_self = 1'b1;
        state_nxt     = S_LINK_PREV;
      end
      S_LINK_PREV: begin
        cmd.link_prev = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/lrut_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrut_dpath: link memories, list pointers and result register
// Holds key and newer/older link memories indexed by slot, the in-use
// bitmap, head/tail pointers, the entry count and the free-slot scanner.
// ----------------------------------------------------------------------------
module lrut_dpath #(
  parameter int CAPACITY = lrut_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = lrut_pkg::DEF_KEY_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lrut_pkg::lrut_in_t   in_data,
  input  wire lrut_pkg::lrut_cmd_t  cmd,
  input  wire logic                 out_stall,
  output lrut_pkg::lrut_stat_t      stat,
  output logic                      out_valid,
  output lrut_pkg::lrut_out_t       out_data
);

  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LINK_W = $clog2(CAPACITY + 1);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int NCHUNK = (CAPACITY + lrut_pkg::SCAN_W - 1) / lrut_pkg::SCAN_W;
  localparam int SCN_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int OFF_W  = $clog2(lrut_pkg::SCAN_W);
  localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

  // slot memories
  logic [KEY_BITS-1:0] key_mem   [CAPACITY];
  logic [LINK_W-1:0]   newer_mem [CAPACITY];
  logic [LINK_W-1:0]   older_mem [CAPACITY];

  logic [KEY_BITS-1:0] rd_key_r;
  logic [LINK_W-1:0]   rd_newer_r, rd_older_r;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [5:0]          res_slot_r, res_slot_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                ev_valid_r, ev_valid_nxt;
  logic [KEY_BITS-1:0] ev_key_r, ev_key_nxt;
  logic [CAPACITY-1:0] inuse_r, inuse_nxt;
  logic [LINK_W-1:0]   newest_r, newest_nxt, oldest_r, oldest_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SCN_W-1:0]    scan_r, scan_nxt;
  logic                out_valid_r, out_valid_nxt;
  lrut_pkg::lrut_out_t out_r, out_nxt;

  logic [IDX_W-1:0]    handle_idx, rd_addr;
  logic                kw_en, nw_en, ow_en;
  logic [IDX_W-1:0]    kw_addr, nw_addr, ow_addr;
  logic [LINK_W-1:0]   nw_data, ow_data;

  logic [NCHUNK*lrut_pkg::SCAN_W-1:0] padded;
  logic [lrut_pkg::SCAN_W-1:0]        chunk;
  logic [OFF_W-1:0]                   free_off;
  logic [IDX_W-1:0]                   found_idx;

  assign handle_idx = IDX_W'(in_data.slot_handle);
  assign rd_addr    = cmd.rd_oldest ? oldest_r[IDX_W-1:0] : handle_idx;

  // status toward the controller
  always_comb begin
    stat.count_zero    = (count_r == '0);
    stat.oldest_nil    = (oldest_r == NIL);
    stat.list_full     = (32'(count_r) >= CAPACITY) && (oldest_r != NIL);
    stat.handle_ok     = (32'(in_data.slot_handle) < CAPACITY) && inuse_r[handle_idx];
    stat.handle_newest = (32'(newest_r) == 32'(in_data.slot_handle));
    stat.scan_found    = |(~chunk);
    stat.out_busy      = out_valid_r && out_stall;
  end

  // lowest free slot in the current chunk, slots past capacity look used
  always_comb begin
    padded                 = '1;
    padded[CAPACITY-1:0]   = inuse_r;
    chunk                  = padded[scan_r * lrut_pkg::SCAN_W +: lrut_pkg::SCAN_W];
    free_off               = '0;
    for (int i = lrut_pkg::SCAN_W - 1; i >= 0; i--) begin
      if (!chunk[i]) begin
        free_off = OFF_W'(i);
      end
    end
    found_idx = IDX_W'(32'(scan_r) * lrut_pkg::SCAN_W + 32'(free_off));
  end

  always_comb begin
    key_nxt       = key_r;
    cur_nxt       = cur_r;
    res_slot_nxt  = res_slot_r;
    status_nxt    = status_r;
    ev_valid_nxt  = ev_valid_r;
    ev_key_nxt    = ev_key_r;
    inuse_nxt     = inuse_r;
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    kw_en         = 1'b0;
    kw_addr       = cur_r;
    nw_en         = 1'b0;
    nw_addr       = cur_r;
    nw_data       = NIL;
    ow_en         = 1'b0;
    ow_addr       = cur_r;
    ow_data       = NIL;

    if (cmd.load_req) begin
      key_nxt      = KEY_BITS'(in_data.entry_key);
      cur_nxt      = rd_addr;
      res_slot_nxt = cmd.echo_handle ? in_data.slot_handle : 6'd0;
      status_nxt   = cmd.set_status;
      ev_valid_nxt = 1'b0;
      ev_key_nxt   = '0;
    end

    if (cmd.scan_start) begin
      scan_nxt = '0;
    end

    if (cmd.unlink) begin
      if (rd_newer_r == NIL) begin
        newest_nxt = rd_older_r;
      end else begin
        ow_en   = 1'b1;
        ow_addr = rd_newer_r[IDX_W-1:0];
        ow_data = rd_older_r;
      end
      if (rd_older_r == NIL) begin
        oldest_nxt = rd_newer_r;
      end else begin
        nw_en   = 1'b1;
        nw_addr = rd_older_r[IDX_W-1:0];
        nw_data = rd_newer_r;
      end
    end

    if (cmd.pop) begin
      ev_valid_nxt = 1'b1;
      ev_key_nxt   = rd_key_r;
      res_slot_nxt = 6'(cur_r);
    end

    if (cmd.release_slot) begin
      inuse_nxt[cur_r] = 1'b0;
      count_nxt        = count_r - CNT_W'(1);
    end

    if (cmd.scan_step) begin
      if (|(~chunk)) begin
        kw_en                = 1'b1;
        kw_addr              = found_idx;
        inuse_nxt[found_idx] = 1'b1;
        count_nxt            = count_r + CNT_W'(1);
        cur_nxt              = found_idx;
        res_slot_nxt         = 6'(found_idx);
      end else begin
        scan_nxt = scan_r + SCN_W'(1);
      end
    end

    if (cmd.link_self) begin
      nw_en   = 1'b1;
      nw_addr = cur_r;
      nw_data = NIL;
      ow_en   = 1'b1;
      ow_addr = cur_r;
      ow_data = newest_r;
    end

    if (cmd.link_prev) begin
      if (newest_r != NIL) begin
        nw_en   = 1'b1;
        nw_addr = newest_r[IDX_W-1:0];
        nw_data = LINK_W'(cur_r);
      end else begin
        oldest_nxt = LINK_W'(cur_r);
      end
      newest_nxt = LINK_W'(cur_r);
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt         = 1'b1;
      out_nxt.status        = status_r;
      out_nxt.slot          = res_slot_r;
      out_nxt.evicted_valid = ev_valid_r;
      out_nxt.evicted_key   = 16'(ev_key_r);
      out_nxt.occupancy     = 7'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr] <= key_r;
    end
    if (nw_en) begin
      newer_mem[nw_addr] <= nw_data;
    end
    if (ow_en) begin
      older_mem[ow_addr] <= ow_data;
    end
    if (cmd.rd_en) begin
      rd_key_r   <= key_mem[rd_addr];
      rd_newer_r <= newer_mem[rd_addr];
      rd_older_r <= older_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inuse_r     <= '0;
      newest_r    <= NIL;
      oldest_r    <= NIL;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      inuse_r     <= inuse_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    cur_r      <= cur_nxt;
    res_slot_r <= res_slot_nxt;
    status_r   <= status_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_key_r   <= ev_key_nxt;
    scan_r     <= scan_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- rtl/lru_list_tracker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_list_tracker: recency list over CAPACITY slots
// Requests (insert, touch, remove, evict) come in on in_valid/in_stall/
// in_data; one result per request leaves on out_valid/out_stall/out_data.
// One request is worked at a time; in_stall is high from the cycle after
// acceptance until the result is moved into the output register.
// Flagged requests (empty list, slot not in use, touch of newest) go
// straight to the result; remove and evict unlink one slot, touch also
// relinks it as newest, and insert evicts the oldest when the list is full,
// then searches for a free slot and links it as newest. The link memories
// share one read port. The result is loaded at the edge where in_stall drops.
// A stalled result stays in the output register while the next request is
// accepted and worked; that request then waits for the register to empty.
// Reset empties the list at once; slot memories need no clearing pass.
// ----------------------------------------------------------------------------
module lru_list_tracker #(
  parameter int CAPACITY = lrut_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = lrut_pkg::DEF_KEY_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire lrut_pkg::lrut_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output lrut_pkg::lrut_out_t      out_data
);

  lrut_pkg::lrut_cmd_t  cmd;
  lrut_pkg::lrut_stat_t stat;

  lrut_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .stat        (stat),
    .in_stall    (in_stall),
    .cmd         (cmd)
  );

  lrut_dpath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one request in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while previous one still in flight");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_data.occupancy) <= CAPACITY))
    else $error("occupancy above capacity");

  a_evict_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.evicted_valid) |-> (out_data.status == lrut_pkg::ST_OK))
    else $error("eviction reported with error status");

  // the result register only loads when it is free or being drained
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_data) && out_valid))
    else $error("stalled result overwritten");

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lru list tracker
// Runs a short directed sequence through the empty, single-entry, middle,
// oldest and newest cases, then about six hundred random requests in phases
// that fill the list, drain it and run it full so that inserts evict. The
// expected result of every request is worked out by a recency-list predictor
// kept inside a scoreboard. Each returned result is compared field by field.
// Both handshakes idle at random, and once the result side holds off long
// enough to back up the request side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CAP = 64;
  localparam logic [6:0] NIL = 7'd64;
  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD = 300;

  // recency-list predictor plus the queue of results still owed by the block
  class recency_scoreboard;
    logic [15:0] key_of [CAP];
    logic [6:0]  newer_of [CAP];
    logic [6:0]  older_of [CAP];
    bit   [63:0] occupied;
    logic [6:0]  newest;
    logic [6:0]  oldest;
    logic [6:0]  count;
    lrut_pkg::lrut_out_t expected_results [$];
    int unsigned errors, requests, results, evictions, full_inserts, flagged;

    function new();
      occupied = '0;
      newest = NIL;
      oldest = NIL;
      count = '0;
      errors = 0;
      requests = 0;
      results = 0;
      evictions = 0;
      full_inserts = 0;
      flagged = 0;
    endfunction

    function void unlink(logic [6:0] s);
      logic [6:0] o, n;
      o = older_of[s];
      n = newer_of[s];
      if (n == NIL) newest = o;
      else older_of[n] = o;
      if (o == NIL) oldest = n;
      else newer_of[o] = n;
    endfunction

    function void link_newest(logic [6:0] s);
      newer_of[s] = NIL;
      older_of[s] = newest;
      if (newest == NIL) oldest = s;
      else newer_of[newest] = s;
      newest = s;
    endfunction

    function void pop_oldest(ref lrut_pkg::lrut_out_t res);
      logic [6:0] s;
      s = oldest;
      res.evicted_valid = 1'b1;
      res.evicted_key = key_of[s];
      unlink(s);
      occupied[s] = 1'b0;
      count--;
      evictions++;
      res.slot = s[5:0];
    endfunction

    // a slot in use chosen at random, or the newest one on request
    function logic [5:0] pick_live(bit want_newest);
      int unsigned start, idx;
      start = $urandom_range(0, CAP - 1);
      if (count == 0) return start[5:0];
      if (want_newest) return newest[5:0];
      for (int i = 0; i < CAP; i++) begin
        idx = (start + i) % CAP;
        if (occupied[idx]) return idx[5:0];
      end
      return start[5:0];
    endfunction

    function void note_request(lrut_pkg::lrut_in_t r);
      lrut_pkg::lrut_out_t res;
      int unsigned s;
      res = '0;
      requests++;
      case (r.req_type)
        lrut_pkg::REQ_INSERT: begin
          if (count == CAP) begin
            pop_oldest(res);
            full_inserts++;
          end
          s = 0;
          while (occupied[s]) s++;
          key_of[s] = r.entry_key;
          occupied[s] = 1'b1;
          link_newest(s[6:0]);
          count++;
          res.slot = s[5:0];
        end
        lrut_pkg::REQ_EVICT: begin
          if (count == 0) res.status = lrut_pkg::ST_EMPTY;
          else pop_oldest(res);
        end
        default: begin
          res.slot = r.slot_handle;
          if (count == 0) begin
            res.status = lrut_pkg::ST_EMPTY;
          end else if (!occupied[r.slot_handle]) begin
            res.status = lrut_pkg::ST_NOT_USED;
          end else if (r.req_type == lrut_pkg::REQ_TOUCH) begin
            if (newest != {1'b0, r.slot_handle}) begin
              unlink({1'b0, r.slot_handle});
              link_newest({1'b0, r.slot_handle});
            end
          end else begin
            unlink({1'b0, r.slot_handle});
            occupied[r.slot_handle] = 1'b0;
            count--;
          end
        end
      endcase
      if (res.status != lrut_pkg::ST_OK) flagged++;
      res.occupancy = count;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(lrut_pkg::lrut_out_t got);
      lrut_pkg::lrut_out_t want;
      results++;
      if (expected_results.size() == 0) begin
        $error("result with no request outstanding: 0x%0h", got);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("slot", 32'(want.slot), 32'(got.slot));
      compare_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
      compare_field("evicted_key", 32'(want.evicted_key), 32'(got.evicted_key));
      compare_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  lrut_pkg::lrut_in_t  in_data;
  logic                out_valid;
  logic                out_stall;
  lrut_pkg::lrut_out_t out_data;

  recency_scoreboard recency;
  bit sender_quiet;
  bit sink_quiet;
  bit sink_long_hold;
  int unsigned idle_cycles;

  lru_list_tracker i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) recency.note_request(in_data);
      if (out_valid && !out_stall) recency.check_result(out_data);
    end
  end

  // ends the run when neither side moves anything for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall ahead of each result, one long hold on demand
  initial begin : result_sink
    int unsigned hold;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      hold = sink_quiet ? 0 : $urandom_range(0, 11);
      if (sink_long_hold) begin
        hold = LONG_HOLD;
        sink_long_hold = 1'b0;
      end
      if (hold != 0) begin
        @(negedge clk);
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  function automatic lrut_pkg::lrut_in_t make_request(logic [1:0] kind, logic [15:0] key,
                                                      logic [5:0] handle);
    lrut_pkg::lrut_in_t r;
    r.req_type = kind;
    r.entry_key = key;
    r.slot_handle = handle;
    return r;
  endfunction

  // mostly well-formed requests on live slots, some on random handles
  function automatic lrut_pkg::lrut_in_t random_request(int unsigned insert_pct);
    lrut_pkg::lrut_in_t r;
    int unsigned roll, rest, span;
    r.entry_key = 16'($urandom_range(0, 65535));
    r.slot_handle = 6'($urandom_range(0, CAP - 1));
    roll = $urandom_range(0, 99);
    rest = roll - insert_pct;
    span = 100 - insert_pct;
    if (roll < insert_pct) r.req_type = lrut_pkg::REQ_INSERT;
    else if (rest * 20 < span * 9) r.req_type = lrut_pkg::REQ_TOUCH;
    else if (rest * 20 < span * 16) r.req_type = lrut_pkg::REQ_REMOVE;
    else r.req_type = lrut_pkg::REQ_EVICT;
    if ((r.req_type == lrut_pkg::REQ_TOUCH || r.req_type == lrut_pkg::REQ_REMOVE) &&
        $urandom_range(0, 99) < 85)
      r.slot_handle = recency.pick_live($urandom_range(0, 9) == 0);
    return r;
  endfunction

  // called and returns at a falling edge, after the request was taken
  task automatic drive_request(input lrut_pkg::lrut_in_t req);
    int unsigned gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin : stimulus
    lrut_pkg::lrut_in_t directed [$];
    int unsigned phase_mix [6] = '{60, 85, 40, 90, 15, 50};
    in_valid = 1'b0;
    in_data = '0;
    rst_n = 1'b0;
    sender_quiet = 1'b0;
    sink_quiet = 1'b0;
    sink_long_hold = 1'b0;
    idle_cycles = 0;
    recency = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty list, then a short list worked at its ends and middle
    directed.push_back(make_request(lrut_pkg::REQ_EVICT,  16'h0000, 6'd0));
    directed.push_back(make_request(lrut_pkg::REQ_TOUCH,  16'hffff, 6'd7));
    directed.push_back(make_request(lrut_pkg::REQ_REMOVE, 16'h0000, 6'd63));
    directed.push_back(make_request(lrut_pkg::REQ_INSERT, 16'h0000, 6'd63));
    directed.push_back(make_request(lrut_pkg::REQ_INSERT, 16'hffff, 6'd0));
    directed.push_back(make_request(lrut_pkg::REQ_INSERT, 16'ha5a5, 6'd21));
    directed.push_back(make_request(lrut_pkg::REQ_TOUCH,  16'h0000, 6'd2));
    directed.push_back(make_request(lrut_pkg::REQ_TOUCH,  16'h0000, 6'd0));
    directed.push_back(make_request(lrut_pkg::REQ_TOUCH,  16'h0000, 6'd63));
    directed.push_back(make_request(lrut_pkg::REQ_REMOVE, 16'h0000, 6'd40));
    directed.push_back(make_request(lrut_pkg::REQ_REMOVE, 16'h0000, 6'd2));
    directed.push_back(make_request(lrut_pkg::REQ_INSERT, 16'h5a5a, 6'd42));
    directed.push_back(make_request(lrut_pkg::REQ_EVICT,  16'hffff, 6'd63));
    directed.push_back(make_request(lrut_pkg::REQ_TOUCH,  16'h0000, 6'd1));
    directed.push_back(make_request(lrut_pkg::REQ_REMOVE, 16'h0000, 6'd0));
    directed.push_back(make_request(lrut_pkg::REQ_REMOVE, 16'h0000, 6'd2));
    directed.push_back(make_request(lrut_pkg::REQ_EVICT,  16'h0000, 6'd0));
    directed.push_back(make_request(lrut_pkg::REQ_INSERT, 16'h8001, 6'd63));
    directed.push_back(make_request(lrut_pkg::REQ_TOUCH,  16'h0000, 6'd0));
    directed.push_back(make_request(lrut_pkg::REQ_REMOVE, 16'hffff, 6'd0));
    directed.push_back(make_request(lrut_pkg::REQ_INSERT, 16'h1234, 6'd21));
    directed.push_back(make_request(lrut_pkg::REQ_EVICT,  16'h0000, 6'd42));
    foreach (directed[i]) drive_request(directed[i]);

    // phases alternate between filling, running full and draining
    foreach (phase_mix[p]) begin
      sender_quiet = (p == 2) || (p == 4);
      sink_quiet = (p == 2);
      if (p == 3) sink_long_hold = 1'b1;
      repeat (100) drive_request(random_request(phase_mix[p]));
    end
    in_valid = 1'b0;

    while (recency.expected_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("covered %0d requests and %0d results", recency.requests, recency.results);
    $display("%0d evictions, %0d inserts into a full list, %0d flagged, one %0d-cycle hold-off",
             recency.evictions, recency.full_inserts, recency.flagged, LONG_HOLD);
    if (recency.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
